// File: sv/rrjs_pkg.sv
`timescale 1ns / 1ps
// Package for the random range and jitter scale core.
// Holds the pipeline item type, stage numbering and the per-stage step functions.
package rrjs_pkg;

    localparam int DIV1_STEPS = 32;
    localparam int DIV2_STEPS = 16;
    localparam int REJ_STAGE  = DIV1_STEPS + 1;
    localparam int DIV2_FIRST = REJ_STAGE + 1;
    localparam int MUL_STAGE  = DIV2_FIRST + DIV2_STEPS;
    localparam int LAST_STAGE = MUL_STAGE;

    typedef struct packed {
        logic        op;
        logic [15:0] lo;
        logic        bad;
        logic        eq;
        logic        rej;
        logic [16:0] span;
        logic [31:0] base;
        logic [31:0] rem_word;
        logic [16:0] rem_band;
        logic [31:0] band;
        logic [15:0] quo;
        logic [47:0] prod;
    } item_t;

    // One bit of band = 0xFFFFFFFF / span.
    function automatic item_t band_step(input item_t it);
        item_t       nx;
        logic [17:0] r2;
        logic        ge;
        nx = it;
        r2 = {it.rem_band, 1'b1};
        ge = (r2 >= {1'b0, it.span});
        nx.rem_band = ge ? 17'(r2 - {1'b0, it.span}) : r2[16:0];
        nx.band = {it.band[30:0], ge};
        return nx;
    endfunction

    // Flag a word at or above band * span, which equals 0xFFFFFFFF - remainder.
    function automatic item_t reject_step(input item_t it);
        item_t nx;
        nx = it;
        nx.rej = !it.bad && !it.eq && (it.rem_word >= ~{15'd0, it.rem_band});
        return nx;
    endfunction

    // One quotient bit of word / band, bit position pos.
    function automatic item_t quo_step(input item_t it, input int pos);
        item_t       nx;
        logic [47:0] shifted;
        logic        ge;
        nx = it;
        shifted = {16'd0, it.band} << pos;
        ge = ({16'd0, it.rem_word} >= shifted);
        nx.rem_word = ge ? 32'(it.rem_word - shifted[31:0]) : it.rem_word;
        nx.quo = it.quo | (16'(ge) << pos);
        return nx;
    endfunction

    // Form the drawn value and the raw product base * drawn.
    function automatic item_t mul_step(input item_t it);
        item_t       nx;
        logic [15:0] drawn;
        nx = it;
        drawn = it.eq ? it.lo : 16'(it.lo + it.quo);
        nx.quo = drawn;
        nx.prod = 48'(it.base) * 48'(drawn);
        return nx;
    endfunction

endpackage

// File: sv/random_range_and_jitter_scale_core.sv
`timescale 1ns / 1ps
// Top level of the random range and jitter scale core.
// Depends on rrjs_pkg for the item type, stage numbering and step functions.
//
// Takes one item per clock while the output is not stalled.
// The path is an input register, a 32-stage restoring divider that forms the
// band width, one stage that tests the word against the last full band, a
// 16-stage divider that forms the band index, and one stage that multiplies
// the base by the drawn factor. An output register then saturates and selects
// the result. A stall on the output freezes the whole pipeline, and in_stall
// follows it in the same cycle.
module random_range_and_jitter_scale_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        operation,
    input  logic [15:0] range_low,
    input  logic [15:0] range_high,
    input  logic [31:0] base_value,
    input  logic [31:0] random_word,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        rejected,
    output logic        bad_range,
    output logic        saturated,
    output logic [31:0] result_value
);

    rrjs_pkg::item_t pipe_reg  [0:rrjs_pkg::LAST_STAGE];
    rrjs_pkg::item_t pipe_next [0:rrjs_pkg::LAST_STAGE];
    logic [rrjs_pkg::LAST_STAGE:0] vld_reg;
    logic        out_valid_reg;
    logic        rejected_reg;
    logic        bad_range_reg;
    logic        saturated_reg;
    logic [31:0] result_value_reg;
    logic        advance;
    logic        ok;
    logic        rejected_next;
    logic        saturated_next;
    logic [31:0] result_value_next;
    rrjs_pkg::item_t tail;

    assign advance  = !(out_valid_reg && out_stall);
    assign in_stall = !advance;

    always_comb
    begin
        pipe_next[0]          = '0;
        pipe_next[0].op       = operation;
        pipe_next[0].lo       = range_low;
        pipe_next[0].bad      = (range_low > range_high);
        pipe_next[0].eq       = (range_low == range_high);
        pipe_next[0].span     = 17'({1'b0, range_high} + 17'd1 - {1'b0, range_low});
        pipe_next[0].base     = base_value;
        pipe_next[0].rem_word = random_word;
    end

    for (genvar s = 1; s <= rrjs_pkg::LAST_STAGE; s++)
    begin : g_stage
        if (s <= rrjs_pkg::DIV1_STEPS)
        begin : g_band
            assign pipe_next[s] = rrjs_pkg::band_step(pipe_reg[s-1]);
        end
        else if (s == rrjs_pkg::REJ_STAGE)
        begin : g_rej
            assign pipe_next[s] = rrjs_pkg::reject_step(pipe_reg[s-1]);
        end
        else if (s < rrjs_pkg::MUL_STAGE)
        begin : g_quo
            assign pipe_next[s] =
                rrjs_pkg::quo_step(pipe_reg[s-1], rrjs_pkg::MUL_STAGE - 1 - s);
        end
        else
        begin : g_mul
            assign pipe_next[s] = rrjs_pkg::mul_step(pipe_reg[s-1]);
        end
    end

    assign tail          = pipe_reg[rrjs_pkg::LAST_STAGE];
    assign ok            = !tail.bad && !tail.rej;
    assign rejected_next = tail.rej;

    always_comb
    begin
        saturated_next    = 1'b0;
        result_value_next = '0;
        if (ok)
        begin
            if (!tail.op)
            begin
                result_value_next = {16'd0, tail.quo};
            end
            else if (tail.prod[47])
            begin
                saturated_next    = 1'b1;
                result_value_next = '1;
            end
            else
            begin
                result_value_next = tail.prod[46:15];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            vld_reg       <= {vld_reg[rrjs_pkg::LAST_STAGE-1:0], in_valid};
            out_valid_reg <= vld_reg[rrjs_pkg::LAST_STAGE];
        end
    end

    // hold payload while stalled
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int s = 0; s <= rrjs_pkg::LAST_STAGE; s++)
            begin
                pipe_reg[s] <= pipe_next[s];
            end
            rejected_reg     <= rejected_next;
            bad_range_reg    <= tail.bad;
            saturated_reg    <= saturated_next;
            result_value_reg <= result_value_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign rejected     = rejected_reg;
    assign bad_range    = bad_range_reg;
    assign saturated    = saturated_reg;
    assign result_value = result_value_reg;

endmodule

// File: sv/rrjs_checker.sv
`timescale 1ns / 1ps
// Port checker for the random range and jitter scale core.
// Watches the top-level ports only; bound to the core below.
module rrjs_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic        rejected,
    input logic        bad_range,
    input logic        saturated,
    input logic [31:0] result_value
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(result_value))
        else $error("result dropped or changed under stall");

    a_bad: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && bad_range |-> !rejected && !saturated && result_value == 32'd0)
        else $error("bad range result not cleared");

    a_rej: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && rejected |-> !saturated && result_value == 32'd0)
        else $error("rejected result not cleared");

    a_sat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && saturated |-> result_value == 32'hFFFF_FFFF)
        else $error("saturated result not all ones");

    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall == (out_valid && out_stall))
        else $error("input stall out of step with output");

endmodule

bind random_range_and_jitter_scale_core rrjs_checker u_rrjs_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .rejected     (rejected),
    .bad_range    (bad_range),
    .saturated    (saturated),
    .result_value (result_value)
);

// File: test/random_range_and_jitter_scale_checker.sv
`timescale 1ns / 1ps
// Checker for the random range and jitter scale core.
// Watches both channels, predicts each result and compares it; stands alone.
module random_range_and_jitter_scale_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic        operation,
    input  logic [15:0] range_low,
    input  logic [15:0] range_high,
    input  logic [31:0] base_value,
    input  logic [31:0] random_word,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic        rejected,
    input  logic        bad_range,
    input  logic        saturated,
    input  logic [31:0] result_value,
    output int          fail_count,
    output int          pending
);

    typedef struct packed {
        logic        rej;
        logic        bad;
        logic        sat;
        logic [31:0] value;
    } draw_t;

    draw_t draw_q[$];

    function automatic draw_t draw_result(logic op, logic [15:0] lo, logic [15:0] hi,
                                          logic [31:0] base, logic [31:0] word);
        draw_t       r;
        logic [16:0] span;
        logic [31:0] band;
        logic [32:0] top;
        logic [15:0] drawn;
        logic [63:0] prod;
        logic        ok;
        r = '0;
        ok = 1'b1;
        drawn = lo;
        if (lo > hi) begin
            r.bad = 1'b1;
            ok = 1'b0;
        end
        else if (lo != hi) begin
            span = {1'b0, hi} + 17'd1 - {1'b0, lo};
            band = 32'hFFFF_FFFF / {15'd0, span};
            top = 33'(64'(band) * 64'(span));
            if ({1'b0, word} >= top) begin
                r.rej = 1'b1;
                ok = 1'b0;
            end
            else
                drawn = 16'(lo + 16'(word / band));
        end
        if (ok) begin
            if (!op)
                r.value = {16'd0, drawn};
            else begin
                prod = (64'(base) * 64'(drawn)) >> 15;
                if (prod > 64'hFFFF_FFFF) begin
                    r.sat = 1'b1;
                    r.value = 32'hFFFF_FFFF;
                end
                else
                    r.value = prod[31:0];
            end
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        draw_t e;
        int    errs;
        errs = 0;
        if (!rst_n) begin
            draw_q.delete();
            fail_count <= 0;
            pending <= 0;
        end
        else begin
            if (in_valid && !in_stall)
                draw_q.push_back(draw_result(operation, range_low, range_high,
                                             base_value, random_word));
            if (out_valid && !out_stall) begin
                if (draw_q.size() == 0) begin
                    $error("result transfer with nothing expected");
                    errs++;
                end
                else begin
                    e = draw_q.pop_front();
                    if (rejected !== e.rej) begin
                        $error("rejected: expected %0d, got %0d", e.rej, rejected);
                        errs++;
                    end
                    if (bad_range !== e.bad) begin
                        $error("bad_range: expected %0d, got %0d", e.bad, bad_range);
                        errs++;
                    end
                    if (saturated !== e.sat) begin
                        $error("saturated: expected %0d, got %0d", e.sat, saturated);
                        errs++;
                    end
                    if (result_value !== e.value) begin
                        $error("result_value: expected %h, got %h", e.value, result_value);
                        errs++;
                    end
                end
            end
            fail_count <= fail_count + errs;
            pending <= draw_q.size();
        end
    end

endmodule

// File: test/random_range_and_jitter_scale_core_tb.sv
`timescale 1ns / 1ps
// Testbench top for the random range and jitter scale core.
// Drives stimulus and stalls; depends on the core and its checker module.
module random_range_and_jitter_scale_core_tb;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        operation = 1'b0;
    logic [15:0] range_low = '0;
    logic [15:0] range_high = '0;
    logic [31:0] base_value = '0;
    logic [31:0] random_word = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        rejected;
    logic        bad_range;
    logic        saturated;
    logic [31:0] result_value;
    int          fail_count;
    int          pending;
    bit          hold_off = 1'b0;
    bit          long_hold = 1'b0;

    always #6 clk = ~clk;

    random_range_and_jitter_scale_core u_top (.*);

    random_range_and_jitter_scale_checker u_chk (.*);

    task automatic send_draw(logic op, logic [15:0] lo, logic [15:0] hi,
                             logic [31:0] base, logic [31:0] word);
        operation   <= op;
        range_low   <= lo;
        range_high  <= hi;
        base_value  <= base;
        random_word <= word;
        in_valid    <= 1'b1;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic send_random;
        logic [15:0] lo;
        logic [15:0] hi;
        logic [31:0] w;
        int          k;
        lo = 16'($urandom);
        hi = 16'($urandom);
        k = $urandom_range(0, 9);
        if (k < 5 && lo > hi)
            {lo, hi} = {hi, lo};
        else if (k == 5)
            hi = lo;
        else if (k == 6) begin
            lo = 16'($urandom_range(0, 15));
            hi = 16'($urandom_range(0, 65535));
        end
        else if (k == 7) begin
            lo = 16'($urandom_range(0, 40000));
            hi = lo + 16'($urandom_range(1, 8));
        end
        w = $urandom;
        if ($urandom_range(0, 5) == 0)
            w = 32'hFFFF_FFFF - 32'($urandom_range(0, 70000));
        send_draw(1'($urandom), lo, hi, $urandom, w);
    endtask

    task automatic idle_gap;
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (long_hold)
            out_stall <= 1'b1;
        else if (hold_off)
            out_stall <= ($urandom_range(0, 3) == 0);
        else
            out_stall <= 1'b0;
    end

    initial
    begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_draw(1'b0, 16'd0, 16'd0, 32'd0, 32'hFFFF_FFFF);
        send_draw(1'b1, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'd0);
        send_draw(1'b0, 16'd5, 16'd4, 32'd1, 32'd7);
        send_draw(1'b1, 16'hFFFF, 16'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_draw(1'b0, 16'd0, 16'hFFFF, 32'd0, 32'd0);
        send_draw(1'b0, 16'd0, 16'hFFFF, 32'd0, 32'hFFFF_FFFE);
        send_draw(1'b0, 16'd0, 16'hFFFF, 32'd0, 32'hFFFF_FFFF);
        send_draw(1'b0, 16'd0, 16'd2, 32'd0, 32'hFFFF_FFFF);
        send_draw(1'b0, 16'd0, 16'd2, 32'd0, 32'hFFFF_FFFE);
        send_draw(1'b0, 16'd0, 16'd1, 32'd0, 32'hFFFF_FFFE);
        send_draw(1'b1, 16'd0, 16'd1, 32'hFFFF_FFFF, 32'h8000_0000);
        send_draw(1'b1, 16'h8000, 16'h8000, 32'hFFFF_FFFF, 32'd3);
        send_draw(1'b1, 16'h8000, 16'h8000, 32'h8000_0000, 32'd3);
        send_draw(1'b1, 16'h8001, 16'h8001, 32'hFFFF_FFFF, 32'd3);
        send_draw(1'b1, 16'h7FFF, 16'hFFFF, 32'h1234_5678, 32'h5555_5555);
        send_draw(1'b1, 16'd0, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FF00);
        send_draw(1'b0, 16'h1234, 16'hABCD, 32'hAAAA_AAAA, 32'hAAAA_AAAA);
        send_draw(1'b1, 16'd1, 16'd1, 32'd1, 32'h5555_5555);
        hold_off = 1'b1;
        for (int i = 0; i < 300; i++)
        begin
            if ($urandom_range(0, 4) == 0) idle_gap();
            send_random();
        end
        long_hold = 1'b1;
        fork
            begin
                repeat (150) @(posedge clk);
                long_hold = 1'b0;
            end
            for (int i = 0; i < 120; i++)
                send_random();
        join
        in_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        for (int i = 0; i < 430; i++)
        begin
            if ($urandom_range(0, 6) == 0) idle_gap();
            send_random();
        end
        in_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (60) @(posedge clk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
